// ===== src/sfmcl_pkg.sv =====
// Shared types and constants for the subset-filtered minimum code lookup.
// Used by the controller, datapath, RAM sizing and the port checker.
package sfmcl_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = IDX_W + 1;
  localparam int KEY_W         = 8;
  localparam int CODE_W        = 64;
  localparam int NIBBLES       = CODE_W / 4;
  localparam int EDGE_BITS     = 15;
  localparam int MAX_SWAPS     = 16;
  localparam int LIM_W         = 5;
  localparam int ENTRY_W       = KEY_W + EDGE_BITS + CODE_W;

  // Result status codes
  localparam logic [1:0] ST_LOADED    = 2'd0;
  localparam logic [1:0] ST_FOUND     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Request opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic start;   // capture the accepted request, clear the scan state
    logic scan;    // read the entry at the scan address, advance it
    logic finish;  // form the result, commit a load
  } sfmcl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic quick;      // request needs no table scan
    logic last_addr;  // scan address points at the last stored entry
    logic out_free;   // output register can take a result this cycle
  } sfmcl_stat_t;

endpackage

// ===== src/subset_filtered_min_code_lookup.sv =====
// Top level of the subset-filtered minimum code lookup.
// Depends on sfmcl_pkg, sfmcl_ctrl, sfmcl_dp and sfmcl_ram.
//
// Usage:
//   The slave stream carries requests. tuser[0] is the opcode: load appends
//   an entry (key, code, edge mask) unless the same key and code are stored,
//   query looks up the smallest stored code under a key whose edge mask fits
//   inside the allowed mask and whose length fits the swap limit.
//   The master stream returns exactly one result per request; tuser holds
//   the status (loaded, found, not found, table full).
//
// Timing:
//   Every request that needs the table scans all N stored entries through
//   the single read port of the entry RAM, one entry per cycle, then passes
//   the last-compare state and the finish state, which registers the result
//   once the output register is free. Queries with key 0 or an empty allowed
//   mask, and any request on an empty table, go from acceptance straight to
//   the finish state. One request is in flight at a time; the next is
//   accepted as soon as the result sits in the output register.
//
// Reset clears the entry count and the controller; the table contents need
// no clearing pass. When the receiver stalls, the result holds in the output
// register and the next request finishes its scan, then waits for the slot.
module subset_filtered_min_code_lookup (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] perm_key, [71:8] swap_code, [86:72] edge_mask, [91:87] max_swaps,
  // [95:92] zero
  input  logic [95:0] s_axis_tdata,
  // [0] opcode
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [63:0] best_code, [78:64] best_mask, [83:79] swap_count, [87:84] zero
  output logic [87:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser
);
  import sfmcl_pkg::*;

  sfmcl_cmd_t           cmd;
  sfmcl_stat_t          stat;
  logic [CODE_W-1:0]    best_code;
  logic [EDGE_BITS-1:0] best_mask;
  logic [LIM_W-1:0]     swap_count;

  // sequence: accept, scan, finish
  sfmcl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // unpack the request fields straight into the datapath
  sfmcl_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .opcode_i    (s_axis_tuser[0]),
    .perm_key_i  (s_axis_tdata[7:0]),
    .swap_code_i (s_axis_tdata[71:8]),
    .edge_mask_i (s_axis_tdata[86:72]),
    .max_swaps_i (s_axis_tdata[91:87]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_o    (m_axis_tuser),
    .best_code_o (best_code),
    .best_mask_o (best_mask),
    .swap_count_o(swap_count)
  );

  // pack the result, pad to whole bytes
  assign m_axis_tdata = {4'd0, swap_count, best_mask, best_code};

endmodule

// ===== src/sfmcl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sfmcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ===== src/sfmcl_ctrl.sv =====
// Sequencer for the lookup: accept, scan the table, finish one result.
// Depends on sfmcl_pkg.
module sfmcl_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sfmcl_pkg::sfmcl_stat_t stat_i,
  output sfmcl_pkg::sfmcl_cmd_t  cmd_o
);
  import sfmcl_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_LAST   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = stat_i.quick ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.last_addr) begin
          state_d = S_LAST;
        end
      end
      // last read data is compared in this cycle
      S_LAST: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/sfmcl_dp.sv =====
// Datapath: request registers, entry table, scan compare and result register.
// Depends on sfmcl_pkg and sfmcl_ram.
module sfmcl_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sfmcl_pkg::sfmcl_cmd_t           cmd_i,
  output sfmcl_pkg::sfmcl_stat_t          stat_o,
  input  logic                            opcode_i,
  input  logic [sfmcl_pkg::KEY_W-1:0]     perm_key_i,
  input  logic [sfmcl_pkg::CODE_W-1:0]    swap_code_i,
  input  logic [sfmcl_pkg::EDGE_BITS-1:0] edge_mask_i,
  input  logic [sfmcl_pkg::LIM_W-1:0]     max_swaps_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      status_o,
  output logic [sfmcl_pkg::CODE_W-1:0]    best_code_o,
  output logic [sfmcl_pkg::EDGE_BITS-1:0] best_mask_o,
  output logic [sfmcl_pkg::LIM_W-1:0]     swap_count_o
);
  import sfmcl_pkg::*;

  function automatic logic [LIM_W-1:0] nib_count(input logic [CODE_W-1:0] c);
    logic [LIM_W-1:0] n;
    n = '0;
    for (int i = 0; i < NIBBLES; i++) begin
      if (c[4*i +: 4] != 4'd0) begin
        n = LIM_W'(i + 1);
      end
    end
    return n;
  endfunction

  // request
  logic                 op_q;
  logic [KEY_W-1:0]     key_q;
  logic [CODE_W-1:0]    code_q;
  logic [EDGE_BITS-1:0] mask_q;
  logic [CODE_W-1:0]    limm_q;   // code bits that must be zero under the limit

  // table and scan
  logic [CNT_W-1:0]     count_q;
  logic [IDX_W-1:0]     addr_q;
  logic                 rd_valid_q;
  logic [ENTRY_W-1:0]   rd_data;
  logic [KEY_W-1:0]     e_key;
  logic [EDGE_BITS-1:0] e_mask;
  logic [CODE_W-1:0]    e_code;
  logic                 have_q, dup_q;
  logic [CODE_W-1:0]    best_q;
  logic [EDGE_BITS-1:0] best_m_q;
  logic                 wr_en;
  logic                 table_full;

  // limit
  logic [LIM_W-1:0]     lim_c;
  logic [CODE_W-1:0]    limm_d;

  // result
  logic                 out_valid_q;
  logic [1:0]           res_status;
  logic [CODE_W-1:0]    res_code;
  logic [EDGE_BITS-1:0] res_mask;
  logic [LIM_W-1:0]     res_count;

  assign table_full = (count_q == CNT_W'(TABLE_ENTRIES));

  assign stat_o.quick     = ((opcode_i == OP_QUERY) &&
                             ((perm_key_i == '0) || (edge_mask_i == '0))) ||
                            (count_q == '0);
  assign stat_o.last_addr = ({1'b0, addr_q} == (count_q - CNT_W'(1)));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    lim_c = (max_swaps_i > LIM_W'(MAX_SWAPS)) ? LIM_W'(MAX_SWAPS) : max_swaps_i;
    if (lim_c >= LIM_W'(NIBBLES)) begin
      limm_d = '0;
    end else begin
      limm_d = {CODE_W{1'b1}} << {lim_c, 2'b00};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q   <= opcode_i;
      key_q  <= perm_key_i;
      code_q <= swap_code_i;
      mask_q <= edge_mask_i;
      limm_q <= limm_d;
    end
  end

  assign wr_en = cmd_i.finish && (op_q == OP_LOAD) && !dup_q && !table_full;

  sfmcl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(count_q[IDX_W-1:0]),
    .wr_data_i({key_q, mask_q, code_q}),
    .rd_en_i  (cmd_i.scan),
    .rd_addr_i(addr_q),
    .rd_data_o(rd_data)
  );

  assign {e_key, e_mask, e_code} = rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      addr_q     <= '0;
      rd_valid_q <= 1'b0;
      have_q     <= 1'b0;
      dup_q      <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.scan;
      if (cmd_i.start) begin
        addr_q <= '0;
      end else if (cmd_i.scan) begin
        addr_q <= addr_q + IDX_W'(1);
      end
      if (wr_en) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.start) begin
        have_q <= 1'b0;
        dup_q  <= 1'b0;
      end else if (rd_valid_q && (e_key == key_q)) begin
        if (op_q == OP_LOAD) begin
          if (e_code == code_q) begin
            dup_q <= 1'b1;
          end
        end else if (((e_mask & ~mask_q) == '0) && ((e_code & limm_q) == '0) &&
                     (!have_q || (e_code < best_q))) begin
          have_q <= 1'b1;
        end
      end
    end
  end

  // best entry payload: same qualifying test as have_q
  always_ff @(posedge clk_i) begin
    if (rd_valid_q && (op_q == OP_QUERY) && (e_key == key_q) &&
        ((e_mask & ~mask_q) == '0) && ((e_code & limm_q) == '0) &&
        (!have_q || (e_code < best_q))) begin
      best_q   <= e_code;
      best_m_q <= e_mask;
    end
  end

  always_comb begin
    res_status = ST_LOADED;
    res_code   = '0;
    res_mask   = '0;
    res_count  = '0;
    if (op_q == OP_LOAD) begin
      if (!dup_q && table_full) begin
        res_status = ST_FULL;
      end
    end else if (key_q == '0) begin
      res_status = ST_FOUND;
    end else if ((mask_q != '0) && have_q) begin
      res_status = ST_FOUND;
      res_code   = best_q;
      res_mask   = best_m_q;
      res_count  = nib_count(best_q);
    end else begin
      res_status = ST_NOT_FOUND;
      res_count  = LIM_W'(MAX_SWAPS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_o     <= res_status;
      best_code_o  <= res_code;
      best_mask_o  <= res_mask;
      swap_count_o <= res_count;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/sfmcl_checker.sv =====
// Port-level checker for the lookup, bound to the top level.
// Depends on sfmcl_pkg.
module sfmcl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import sfmcl_pkg::*;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

  // one request at a time: acceptance drops ready
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while busy");

  // load and full results carry an all-zero payload
  a_load_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && ((m_axis_tuser == ST_LOADED) || (m_axis_tuser == ST_FULL)))
      |-> (m_axis_tdata == '0))
    else $error("load result payload not zero");

  // not found: no code, no mask, full swap count
  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ST_NOT_FOUND)) |->
      ((m_axis_tdata[78:0] == '0) && (m_axis_tdata[83:79] == 5'(MAX_SWAPS))))
    else $error("not-found result payload wrong");

endmodule

bind subset_filtered_min_code_lookup sfmcl_checker u_sfmcl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
